[sv/kvs_pkg.sv]
package kvs_pkg;

    localparam int TIME_W   = 32;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;
    localparam int FRAC_W   = 16;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CLAMPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        AXIS_X = 3'b001,
        AXIS_Y = 3'b010,
        AXIS_Z = 3'b100
    } axis_t;

    typedef struct packed {
        logic  load_req;
        logic  rd_start;
        logic  rd_next;
        logic  cursor_load;
        logic  capture_t0;
        logic  capture_t1;
        logic  capture_a;
        logic  capture_b;
        logic  div_start;
        logic  blend_go;
        logic  single_key;
        axis_t axis;
        logic  out_load;
    } kvs_cmd_t;

    typedef struct packed {
        logic func;
        logic search_hit;
        logic search_end;
        logic div_needed;
        logic div_done;
        logic blend_done;
    } kvs_stat_t;

endpackage

[sv/keyframe_vector_sampler_unit.sv]
// channel  direction  payload
// s_axis   in         func in tuser; slot, time, x, y, z, sample in tdata
// m_axis   out        x, y, z, interval, status in tdata
// cfg      in         key_count
// a sample takes longer for each further key scanned; its time is set by the
// forward search over the key memory and the 16-step bit-serial division that
// forms the factor
// reset clears the search cursor and sets key_count to 1; key memory is undefined
// a result waits in its output register while the next item is accepted
module keyframe_vector_sampler_unit
    import kvs_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,  // key_slot, key_time, key_x, key_y, key_z, sample_time
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // out_x, out_y, out_z, interval_used, status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data
);

    logic [CNT_W-1:0] key_count_reg;
    kvs_cmd_t         cmd;
    kvs_stat_t        stat;
    logic             single;
    logic             in_fire, out_fire;
    logic [VAL_W-1:0] rx, ry, rz;
    logic [IDX_W-1:0] ridx;
    logic [STATUS_W-1:0] rst_s;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_count_reg <= CNT_W'(1);
        else if (cfg_valid)
            key_count_reg <= cfg_data;
    end

    kvs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .single(single), .stat(stat), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .cmd(cmd));

    kvs_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .key_count(key_count_reg), .single(single),
        .in_func(s_axis_tuser),
        .in_slot(s_axis_tdata[5:0]),
        .in_time(s_axis_tdata[37:6]),
        .in_x(s_axis_tdata[69:38]),
        .in_y(s_axis_tdata[101:70]),
        .in_z(s_axis_tdata[133:102]),
        .in_sample(s_axis_tdata[165:134]),
        .res_x(rx), .res_y(ry), .res_z(rz), .res_idx(ridx), .res_status(rst_s));

    assign m_axis_tdata = {rst_s, ridx, rz, ry, rx};

    logic unused_ok;
    assign unused_ok = ^s_axis_tdata[167:166];

endmodule

[sv/kvs_ram.sv]
module kvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/kvs_ctrl.sv]
module kvs_ctrl
    import kvs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_fire,
    input  logic      single,
    input  kvs_stat_t stat,
    output logic      in_ready,
    output logic      out_valid,
    output kvs_cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SRD    = 11'b00000000010,
        S_SCHK   = 11'b00000000100,
        S_RD0    = 11'b00000001000,
        S_RD1    = 11'b00000010000,
        S_RDA    = 11'b00000100000,
        S_RDB    = 11'b00001000000,
        S_DIV    = 11'b00010000000,
        S_BLEND  = 11'b00100000000,
        S_BWAIT  = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    axis_t  axis_reg, axis_next;
    logic   pend_reg, pend_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = pend_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        if (out_fire)
        begin
            pend_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_SRD;
                end
            end
            S_SRD:
            begin
                if (!stat.func)
                begin
                    state_next = S_OUT;
                end
                else if (single)
                begin
                    axis_next  = AXIS_X;
                    cmd.single_key = 1'b1;
                    cmd.rd_start   = 1'b1;
                    state_next = S_RD1;
                end
                else
                begin
                    axis_next    = AXIS_X;
                    cmd.rd_start = 1'b1;
                    state_next   = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (stat.search_hit)
                begin
                    cmd.cursor_load = 1'b1;
                    state_next      = S_RD0;
                end
                else if (stat.search_end)
                begin
                    state_next = S_RD0;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.capture_t0 = 1'b1;
                cmd.capture_a  = 1'b1;
                state_next     = S_RDA;
                axis_next      = AXIS_X;
            end
            S_RDA:
            begin
                if (axis_reg == AXIS_X)
                begin
                    cmd.capture_t1 = 1'b1;
                end
                else
                begin
                    cmd.capture_a = 1'b1;
                end
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.capture_b = 1'b1;
                if (axis_reg == AXIS_X)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_BLEND;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                cmd.blend_go = 1'b1;
                state_next   = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (stat.blend_done)
                begin
                    unique case (axis_reg)
                        AXIS_X:
                        begin
                            axis_next  = AXIS_Y;
                            state_next = S_RDA;
                        end
                        AXIS_Y:
                        begin
                            axis_next  = AXIS_Z;
                            state_next = S_RDA;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (!pend_reg || out_fire)
                begin
                    cmd.out_load = 1'b1;
                    pend_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_X;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

[sv/kvs_datapath.sv]
module kvs_datapath
    import kvs_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kvs_cmd_t            cmd,
    output kvs_stat_t           stat,
    input  logic [CNT_W-1:0]    key_count,
    output logic                single,
    input  logic                in_func,
    input  logic [IDX_W-1:0]    in_slot,
    input  logic [TIME_W-1:0]   in_time,
    input  logic [VAL_W-1:0]    in_x,
    input  logic [VAL_W-1:0]    in_y,
    input  logic [VAL_W-1:0]    in_z,
    input  logic [TIME_W-1:0]   in_sample,
    output logic [VAL_W-1:0]    res_x,
    output logic [VAL_W-1:0]    res_y,
    output logic [VAL_W-1:0]    res_z,
    output logic [IDX_W-1:0]    res_idx,
    output logic [STATUS_W-1:0] res_status
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int NW = AW + 1;

    logic                func_reg;
    logic [TIME_W-1:0]   samp_reg;
    logic [AW-1:0]       cursor_reg, cursor_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [NW-1:0]       scan_reg, scan_next;
    logic [NW-1:0]       n_eff;
    logic                rd_valid_reg;
    logic [AW-1:0]       raddr;
    logic [TIME_W-1:0]   t_rd;
    logic [VAL_W-1:0]    x_rd, y_rd, z_rd, v_rd;
    logic                wr_en;
    logic                wr_pend_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [TIME_W-1:0]   wt_reg;
    logic [VAL_W-1:0]    wx_reg, wy_reg, wz_reg;
    logic [TIME_W-1:0]   t0_reg;
    logic [VAL_W-1:0]    a_reg, b_reg;
    logic                single_reg;
    logic                rd_b_reg;

    // division
    logic [TIME_W:0]     num_reg, den_reg;
    logic [FRAC_W:0]     f_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [TIME_W+1:0]   rem_reg;
    logic [TIME_W+1:0]   rem_dbl, trial;
    logic                div_trivial;
    logic [5:0]          dcnt_reg;
    logic                dbusy_reg, ddone_reg;

    // blend
    logic signed [VAL_W:0]        diff_reg;
    logic signed [VAL_W+FRAC_W+2:0] prod_reg;
    logic [1:0]                   bst_reg;
    logic [VAL_W-1:0]             out_x_reg, out_y_reg, out_z_reg;
    logic [VAL_W-1:0]             blend_res;

    always_comb
    begin
        if (key_count == '0)
            n_eff = NW'(1);
        else if (32'(key_count) > 32'(MAX_KEYS))
            n_eff = NW'(MAX_KEYS);
        else
            n_eff = NW'(key_count);
    end

    assign single = (n_eff == NW'(1));

    assign wr_en = wr_pend_reg && !func_reg && (32'(slot_reg) < 32'(MAX_KEYS));

    always_comb
    begin
        raddr = idx_reg;
        if (cmd.rd_start)
            raddr = single ? AW'(0) : AW'(cursor_reg + AW'(1));
        else if (cmd.rd_next)
            raddr = AW'(scan_reg + NW'(2));
        else if (cmd.capture_t0)
            raddr = single_reg ? AW'(0) : AW'(idx_reg + AW'(1));
        else if (cmd.capture_a || cmd.capture_t1)
            raddr = single_reg ? AW'(0) : AW'(idx_reg + AW'(1));
        else if (!rd_b_reg)
            raddr = idx_reg;
    end

    kvs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_time (
        .clk(clk), .we(wr_en), .waddr(AW'(slot_reg)), .wdata(wt_reg),
        .raddr(raddr), .rdata(t_rd));
    kvs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_x (
        .clk(clk), .we(wr_en), .waddr(AW'(slot_reg)), .wdata(wx_reg),
        .raddr(raddr), .rdata(x_rd));
    kvs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_y (
        .clk(clk), .we(wr_en), .waddr(AW'(slot_reg)), .wdata(wy_reg),
        .raddr(raddr), .rdata(y_rd));
    kvs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_z (
        .clk(clk), .we(wr_en), .waddr(AW'(slot_reg)), .wdata(wz_reg),
        .raddr(raddr), .rdata(z_rd));

    always_comb
    begin
        unique case (cmd.axis)
            AXIS_Y:  v_rd = y_rd;
            AXIS_Z:  v_rd = z_rd;
            default: v_rd = x_rd;
        endcase
    end

    assign stat.func       = func_reg;
    assign stat.search_hit = rd_valid_reg && (samp_reg < t_rd)
                             && (scan_reg + NW'(1) < n_eff);
    assign stat.search_end = !rd_valid_reg || (scan_reg + NW'(2) >= n_eff);
    assign stat.div_needed = 1'b1;
    assign stat.div_done   = ddone_reg;
    assign stat.blend_done = (bst_reg == 2'd3);

    always_comb
    begin
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        scan_next   = scan_reg;
        if (cmd.load_req && !in_func)
            cursor_next = '0;
        if (cmd.rd_start)
        begin
            scan_next = NW'(cursor_reg);
            idx_next  = '0;
        end
        if (cmd.rd_next)
            scan_next = scan_reg + NW'(1);
        if (cmd.cursor_load)
        begin
            cursor_next = AW'(scan_reg);
            idx_next    = AW'(scan_reg);
        end
    end

    // division: remainder/quotient restoring, one bit per cycle
    logic signed [TIME_W+1:0] snum, sden;
    always_comb
    begin
        snum = $signed({2'b00, samp_reg}) - $signed({2'b00, t0_reg});
        sden = $signed({2'b00, t_rd}) - $signed({2'b00, t0_reg});
        if (sden < 0)
        begin
            sden = -sden;
            snum = -snum;
        end
    end

    // num<<16 / den, 16 quotient bits
    assign rem_dbl     = {rem_reg[TIME_W:0], 1'b0};
    assign trial       = rem_dbl - {1'b0, den_reg};
    assign div_trivial = (den_reg == '0) || num_reg[TIME_W] || (num_reg == '0)
                         || (num_reg >= den_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= in_func;
            samp_reg <= in_sample;
            slot_reg <= in_slot;
            wt_reg   <= in_time;
            wx_reg   <= in_x;
            wy_reg   <= in_y;
            wz_reg   <= in_z;
        end
        if (cmd.single_key)
            single_reg <= 1'b1;
        else if (cmd.rd_start)
            single_reg <= 1'b0;
        if (cmd.capture_t0)
            t0_reg <= t_rd;
        if (cmd.capture_a)
            a_reg <= v_rd;
        if (cmd.capture_b)
            b_reg <= single_reg ? a_reg : v_rd;
        if (cmd.capture_t1)
        begin
            if (single_reg)
            begin
                num_reg <= '0;
                den_reg <= '0;
            end
            else
            begin
                num_reg <= snum[TIME_W:0];
                den_reg <= sden[TIME_W:0];
            end
        end
        if (cmd.out_load)
        begin
            res_x      <= func_reg ? out_x_reg : '0;
            res_y      <= func_reg ? out_y_reg : '0;
            res_z      <= func_reg ? out_z_reg : '0;
            res_idx    <= func_reg ? IDX_W'(idx_reg) : '0;
            res_status <= func_reg ? st_reg : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            idx_reg      <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            wr_pend_reg  <= 1'b0;
            rd_b_reg     <= 1'b0;
            dbusy_reg    <= 1'b0;
            ddone_reg    <= 1'b0;
            dcnt_reg     <= '0;
            bst_reg      <= '0;
            f_reg        <= '0;
            st_reg       <= STATUS_OK;
            rem_reg      <= '0;
            diff_reg     <= '0;
            prod_reg     <= '0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_z_reg    <= '0;
        end
        else
        begin
            cursor_reg   <= cursor_next;
            idx_reg      <= idx_next;
            scan_reg     <= scan_next;
            rd_valid_reg <= cmd.rd_start || cmd.rd_next;
            wr_pend_reg  <= cmd.load_req;
            rd_b_reg     <= cmd.capture_a;
            ddone_reg    <= (cmd.div_start && div_trivial)
                            || (dbusy_reg && (dcnt_reg == '0));
            if (cmd.div_start)
            begin
                if (den_reg == '0)
                begin
                    f_reg  <= '0;
                    st_reg <= single_reg ? STATUS_OK : STATUS_ZERO;
                end
                else if (num_reg[TIME_W] || num_reg == '0)
                begin
                    f_reg  <= '0;
                    st_reg <= num_reg[TIME_W] ? STATUS_CLAMPED : STATUS_OK;
                end
                else if (num_reg >= den_reg)
                begin
                    f_reg  <= {1'b1, FRAC_W'(0)};
                    st_reg <= (num_reg > den_reg) ? STATUS_CLAMPED : STATUS_OK;
                end
                else
                begin
                    st_reg    <= STATUS_OK;
                    f_reg     <= '0;
                    dbusy_reg <= 1'b1;
                    dcnt_reg  <= 6'(FRAC_W - 1);
                    rem_reg   <= {2'b00, num_reg[TIME_W-1:0]};
                end
            end
            else if (dbusy_reg)
            begin
                if (!trial[TIME_W+1])
                    rem_reg <= trial;
                else
                    rem_reg <= rem_dbl;
                f_reg <= {f_reg[FRAC_W-1:0], !trial[TIME_W+1]};
                if (dcnt_reg == '0)
                    dbusy_reg <= 1'b0;
                else
                    dcnt_reg <= dcnt_reg - 6'd1;
            end
            unique case (bst_reg)
                2'd0:
                begin
                    if (cmd.blend_go)
                    begin
                        diff_reg <= $signed({b_reg[VAL_W-1], b_reg})
                                    - $signed({a_reg[VAL_W-1], a_reg});
                        bst_reg  <= 2'd1;
                    end
                end
                2'd1:
                begin
                    prod_reg <= (VAL_W+FRAC_W+3)'(diff_reg * $signed({1'b0, f_reg}));
                    bst_reg  <= 2'd2;
                end
                2'd2:
                begin
                    unique case (cmd.axis)
                        AXIS_Y:  out_y_reg <= blend_res;
                        AXIS_Z:  out_z_reg <= blend_res;
                        default: out_x_reg <= blend_res;
                    endcase
                    bst_reg <= 2'd3;
                end
                default:
                begin
                    bst_reg <= 2'd0;
                end
            endcase
        end
    end

    assign blend_res = VAL_W'($signed({a_reg[VAL_W-1], a_reg})
                       + $signed(prod_reg[VAL_W+FRAC_W+2:FRAC_W]));

endmodule

[tb/kvs_checker.sv]
`timescale 1ns / 100ps

module kvs_checker
    import kvs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [6:0]   cfg_data,
    output int           errors,
    output int           pending
);

    typedef struct {
        logic [VAL_W-1:0]    x;
        logic [VAL_W-1:0]    y;
        logic [VAL_W-1:0]    z;
        logic [IDX_W-1:0]    interval;
        logic [STATUS_W-1:0] status;
    } track_sample_t;

    logic [TIME_W-1:0] key_times [64];
    logic [VAL_W-1:0]  key_xs [64];
    logic [VAL_W-1:0]  key_ys [64];
    logic [VAL_W-1:0]  key_zs [64];
    int                cursor;
    logic [CNT_W-1:0]  count_reg;
    track_sample_t     sample_queue [$];

    assign pending = sample_queue.size();

    function automatic logic [VAL_W-1:0] lerp(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                              longint f);
        longint va;
        longint vb;
        longint p;
        va = longint'($signed(a));
        vb = longint'($signed(b));
        p  = (vb - va) * f;
        return VAL_W'(va + (p >>> FRAC_W));
    endfunction

    function automatic track_sample_t sample_track(logic [TIME_W-1:0] st);
        track_sample_t r;
        int     n;
        int     idx;
        bit     hit;
        longint num;
        longint den;
        longint f;
        r = '{default: '0};
        n = (count_reg == 0) ? 1 : (count_reg > 64) ? 64 : int'(count_reg);
        if (n == 1)
        begin
            r.x = key_xs[0];
            r.y = key_ys[0];
            r.z = key_zs[0];
            return r;
        end
        idx = 0;
        hit = 0;
        for (int i = cursor; i + 1 < n; i++)
        begin
            if (st < key_times[i+1])
            begin
                idx = i;
                hit = 1;
                break;
            end
        end
        if (hit)
            cursor = idx;
        num = longint'(st) - longint'(key_times[idx]);
        den = longint'(key_times[idx+1]) - longint'(key_times[idx]);
        r.status = STATUS_OK;
        if (den == 0)
        begin
            f = 0;
            r.status = STATUS_ZERO;
        end
        else
        begin
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            if (num <= 0)
            begin
                f = 0;
                if (num < 0)
                    r.status = STATUS_CLAMPED;
            end
            else if (num >= den)
            begin
                f = 65536;
                if (num > den)
                    r.status = STATUS_CLAMPED;
            end
            else
                f = (num * 65536) / den;
        end
        r.x = lerp(key_xs[idx], key_xs[idx+1], f);
        r.y = lerp(key_ys[idx], key_ys[idx+1], f);
        r.z = lerp(key_zs[idx], key_zs[idx+1], f);
        r.interval = IDX_W'(idx);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        track_sample_t want;
        track_sample_t got;
        logic [5:0]    slot;
        if (!rst_n)
        begin
            cursor    <= 0;
            count_reg <= 7'd1;
            errors    <= 0;
            sample_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == FUNC_WRITE)
                begin
                    slot = s_axis_tdata[5:0];
                    key_times[slot] = s_axis_tdata[37:6];
                    key_xs[slot]    = s_axis_tdata[69:38];
                    key_ys[slot]    = s_axis_tdata[101:70];
                    key_zs[slot]    = s_axis_tdata[133:102];
                    cursor = 0;
                    sample_queue.push_back('{default: '0});
                end
                else
                    sample_queue.push_back(sample_track(s_axis_tdata[165:134]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.x        = m_axis_tdata[31:0];
                got.y        = m_axis_tdata[63:32];
                got.z        = m_axis_tdata[95:64];
                got.interval = m_axis_tdata[101:96];
                got.status   = m_axis_tdata[103:102];
                if (sample_queue.size() == 0)
                begin
                    $display("%0t unexpected result %h", $time, m_axis_tdata);
                    errors = errors + 1;
                end
                else
                begin
                    want = sample_queue.pop_front();
                    if (got.x !== want.x)
                    begin
                        $display("%0t out_x expected %h actual %h", $time, want.x, got.x);
                        errors = errors + 1;
                    end
                    if (got.y !== want.y)
                    begin
                        $display("%0t out_y expected %h actual %h", $time, want.y, got.y);
                        errors = errors + 1;
                    end
                    if (got.z !== want.z)
                    begin
                        $display("%0t out_z expected %h actual %h", $time, want.z, got.z);
                        errors = errors + 1;
                    end
                    if (got.interval !== want.interval)
                    begin
                        $display("%0t interval expected %0d actual %0d", $time,
                                 want.interval, got.interval);
                        errors = errors + 1;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import kvs_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [6:0]   cfg_data;
    int           errors;
    int           pending;

    logic [31:0]  track_times [64];
    int           key_total;
    int           items_sent;
    bit           calm;
    int           quiet_cycles;

    keyframe_vector_sampler_unit #(.MAX_KEYS(64)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    kvs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // result side stalls
    always @(posedge clk)
    begin
        if (!calm && $urandom_range(99) < 23)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog on accepted requests, results and config writes
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(logic fn, logic [5:0] slot, logic [31:0] kt, logic [31:0] kx,
                             logic [31:0] ky, logic [31:0] kz, logic [31:0] st);
        if (!calm && $urandom_range(99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 40)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {2'b00, st, kz, ky, kx, kt, slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (fn == FUNC_WRITE)
            track_times[slot] = kt;
    endtask

    task automatic write_key(logic [5:0] slot, logic [31:0] kt);
        send_item(FUNC_WRITE, slot, kt, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic sample_at(logic [31:0] st);
        send_item(FUNC_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, $urandom, st);
    endtask

    task automatic set_key_count(logic [6:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        key_total = (value == 0) ? 1 : (value > 64) ? 64 : int'(value);
    endtask

    function automatic logic [31:0] pick_time();
        int k;
        k = $urandom_range(key_total - 1);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return track_times[k] - $urandom_range(5);
            2:       return track_times[k];
            default: return track_times[k] + $urandom_range(1200);
        endcase
    endfunction

    initial
    begin
        logic [31:0] t;
        int          n;
        int          phase;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 7'd0;
        calm          = 1'b0;
        quiet_cycles  = 0;
        items_sent    = 0;
        key_total     = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single key, extreme values
        send_item(FUNC_WRITE, 6'd0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0);
        sample_at(32'h0);
        sample_at(32'hFFFFFFFF);
        set_key_count(7'd0);
        sample_at(32'h12345678);
        // widest interval
        send_item(FUNC_WRITE, 6'd1, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'hFFFFFFFF, 32'h0);
        set_key_count(7'd2);
        sample_at(32'h0);
        sample_at(32'h7FFFFFFF);
        sample_at(32'hFFFFFFFF);
        send_item(FUNC_WRITE, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF,
                  32'hFFFFFFFF);
        // zero-length interval
        write_key(6'd1, 32'h0);
        sample_at(32'h0);
        sample_at(32'h5);
        // descending times, clamp on both sides
        write_key(6'd0, 32'd200);
        write_key(6'd1, 32'd100);
        sample_at(32'd150);
        sample_at(32'd50);
        sample_at(32'd250);

        phase = 0;
        while (items_sent < 860)
        begin
            calm = (phase % 5 == 2);
            case ($urandom_range(9))
                0:       n = 64;
                1:       n = 127;
                2:       n = $urandom_range(1, 2);
                default: n = $urandom_range(1, 12);
            endcase
            set_key_count(7'(n));
            t = $urandom_range(32'h7FFFFFFF);
            for (int k = 0; k < key_total; k++)
            begin
                if ($urandom_range(9) == 0)
                    write_key(6'(k), $urandom);
                else
                begin
                    write_key(6'(k), t);
                    if ($urandom_range(7) != 0)
                        t = t + $urandom_range(1, 1000);
                end
            end
            repeat ($urandom_range(20, 50))
            begin
                if ($urandom_range(99) < 12)
                begin
                    if ($urandom_range(1) == 0)
                        write_key(6'($urandom), $urandom);
                    else
                    begin
                        n = $urandom_range(key_total - 1);
                        write_key(6'(n), track_times[n] + $urandom_range(3));
                    end
                end
                else
                    sample_at(pick_time());
            end
            phase++;
        end
        set_key_count(7'd64);
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
